// File: hw/rtl/rta_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rta_pkg;

   // Fixed field widths
   localparam int X_W = 16;
   localparam int Y_W = 16;

   // Default fixed-point formats
   localparam int IN_FRAC_BITS_DEF  = 12;
   localparam int OUT_FRAC_BITS_DEF = 14;

   // Magnitude of the sample, 32768 included
   localparam int AX_W = X_W;

   // Control fields that travel with every pipeline stage
   typedef struct packed {
      logic valid;
      logic last;
      logic neg;
      logic sat;
   } ctl_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // Width of the numerator x*(27*2^2F + x^2)
   function automatic int num_width(input int f);
      return max_int(AX_W + 5 + 2 * f, 3 * AX_W) + 1;
   endfunction

   // Width of the denominator 27*2^2F + 9*x^2
   function automatic int den_width(input int f);
      return max_int(5 + 2 * f, 2 * AX_W + 4) + 1;
   endfunction

   // Width of the divider remainder: holds up to twice den << F
   function automatic int rem_width(input int f);
      return den_width(f) + f + 1;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rta_front.sv
`timescale 1ns / 1ps
`default_nettype none

module rta_front #(
   parameter int IN_FRAC_BITS = rta_pkg::IN_FRAC_BITS_DEF
) (
   input  wire                                             clock,
   input  wire                                             reset,
   input  wire                                             en,
   input  wire                                             in_valid,
   input  wire  signed [rta_pkg::X_W-1:0]                  in_x,
   input  wire                                             in_last,
   output rta_pkg::ctl_type                                ctl_out,
   output logic [rta_pkg::rem_width(IN_FRAC_BITS)-1:0]     rem_out,
   output logic [rta_pkg::den_width(IN_FRAC_BITS)-1:0]     den_out
);

   localparam int AX_W    = rta_pkg::AX_W;
   localparam int SQ_W    = 2 * AX_W;
   localparam int A27_W   = AX_W + 5;
   localparam int CUBE_W  = 3 * AX_W;
   localparam int NUM_W   = rta_pkg::num_width(IN_FRAC_BITS);
   localparam int DEN_W   = rta_pkg::den_width(IN_FRAC_BITS);
   localparam int REM_W   = rta_pkg::rem_width(IN_FRAC_BITS);
   localparam int CMP_W   = rta_pkg::max_int(AX_W, IN_FRAC_BITS + 2) + 1;
   localparam logic [CMP_W-1:0] THREE_LIM = CMP_W'(3) << IN_FRAC_BITS;
   localparam logic [DEN_W-1:0] K27_DEN   = DEN_W'(27) << (2 * IN_FRAC_BITS);

   // Stage 1: magnitude, sign and saturation flag
   logic [rta_pkg::X_W-1:0] x_u;
   logic [AX_W-1:0]         ax1_in, ax1_ff;
   rta_pkg::ctl_type        ctl1_in, ctl1_ff;

   always_comb begin
      x_u           = in_x;
      ax1_in        = x_u[rta_pkg::X_W-1] ? AX_W'(~x_u + 1'b1) : AX_W'(x_u);
      ctl1_in.valid = in_valid;
      ctl1_in.last  = in_last;
      ctl1_in.neg   = x_u[rta_pkg::X_W-1];
      ctl1_in.sat   = CMP_W'(ax1_in) > THREE_LIM;
   end

   // Stage 2: square and 27*|x|
   logic [SQ_W-1:0]  sq2_in, sq2_ff;
   logic [A27_W-1:0] a27_2_in, a27_2_ff;
   logic [AX_W-1:0]  ax2_ff;
   rta_pkg::ctl_type ctl2_ff;

   assign sq2_in   = SQ_W'(ax1_ff) * SQ_W'(ax1_ff);
   assign a27_2_in = A27_W'(ax1_ff) * A27_W'(27);

   // Stage 3: cube and denominator
   logic [CUBE_W-1:0] cube3_in, cube3_ff;
   logic [DEN_W-1:0]  den3_in, den3_ff;
   logic [A27_W-1:0]  a27_3_ff;
   rta_pkg::ctl_type  ctl3_ff;

   assign cube3_in = CUBE_W'(sq2_ff) * CUBE_W'(ax2_ff);
   assign den3_in  = K27_DEN + (DEN_W'(sq2_ff) << 3) + DEN_W'(sq2_ff);

   // Stage 4: numerator, loaded as the divider's first remainder
   logic [NUM_W-1:0] num4;
   logic [REM_W-1:0] rem4_in, rem4_ff;
   logic [DEN_W-1:0] den4_ff;
   rta_pkg::ctl_type ctl4_ff;

   assign num4    = (NUM_W'(a27_3_ff) << (2 * IN_FRAC_BITS)) + NUM_W'(cube3_ff);
   // saturated samples skip the quotient, so the divider gets a zero
   assign rem4_in = ctl3_ff.sat ? '0 : REM_W'(num4);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff.valid <= 1'b0;
         ctl2_ff.valid <= 1'b0;
         ctl3_ff.valid <= 1'b0;
         ctl4_ff.valid <= 1'b0;
      end else if (en) begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   // Data registers
   always_ff @(posedge clock) begin
      if (en) begin
         ax1_ff   <= ax1_in;
         sq2_ff   <= sq2_in;
         a27_2_ff <= a27_2_in;
         ax2_ff   <= ax1_ff;
         cube3_ff <= cube3_in;
         den3_ff  <= den3_in;
         a27_3_ff <= a27_2_ff;
         rem4_ff  <= rem4_in;
         den4_ff  <= den3_ff;
      end
   end

   assign ctl_out = ctl4_ff;
   assign rem_out = rem4_ff;
   assign den_out = den4_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rta_div.sv
`timescale 1ns / 1ps
`default_nettype none

module rta_div #(
   parameter int IN_FRAC_BITS  = rta_pkg::IN_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS = rta_pkg::OUT_FRAC_BITS_DEF
) (
   input  wire                                             clock,
   input  wire                                             reset,
   input  wire                                             en,
   input  rta_pkg::ctl_type                                ctl_in,
   input  wire  [rta_pkg::rem_width(IN_FRAC_BITS)-1:0]     rem_in,
   input  wire  [rta_pkg::den_width(IN_FRAC_BITS)-1:0]     den_in,
   output rta_pkg::ctl_type                                ctl_out,
   output logic [OUT_FRAC_BITS:0]                          q_out
);

   localparam int DEN_W  = rta_pkg::den_width(IN_FRAC_BITS);
   localparam int REM_W  = rta_pkg::rem_width(IN_FRAC_BITS);
   localparam int DD_W   = DEN_W + IN_FRAC_BITS;
   localparam int Q_W    = OUT_FRAC_BITS + 1;
   localparam int STAGES = Q_W;

   // One quotient bit per stage, most significant (weight one) first
   rta_pkg::ctl_type ctl_ff [STAGES];
   logic [REM_W-1:0] rem_ff [STAGES];
   logic [DEN_W-1:0] den_ff [STAGES];
   logic [Q_W-1:0]   q_ff   [STAGES];

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      rta_pkg::ctl_type ctl_prev;
      logic [REM_W-1:0] rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [Q_W-1:0]   q_prev;
      logic [REM_W-1:0] dd;
      logic [REM_W-1:0] diff;
      logic             ge;
      logic [REM_W-1:0] rem_in_j;
      logic [Q_W-1:0]   q_in_j;

      if (j == 0) begin : g_first
         assign ctl_prev = ctl_in;
         assign rem_prev = rem_in;
         assign den_prev = den_in;
         assign q_prev   = '0;
      end else begin : g_next
         assign ctl_prev = ctl_ff[j-1];
         assign rem_prev = rem_ff[j-1];
         assign den_prev = den_ff[j-1];
         assign q_prev   = q_ff[j-1];
      end

      // Trial subtract of den << F, then shift the partial remainder
      always_comb begin
         dd       = REM_W'(DD_W'(den_prev) << IN_FRAC_BITS);
         ge       = rem_prev >= dd;
         diff     = rem_prev - dd;
         rem_in_j = ge ? (diff << 1) : (rem_prev << 1);
         q_in_j   = {q_prev[Q_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j].valid <= 1'b0;
         end else if (en) begin
            ctl_ff[j] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j] <= rem_in_j;
            den_ff[j] <= den_prev;
            q_ff[j]   <= q_in_j;
         end
      end
   end

   assign ctl_out = ctl_ff[STAGES-1];
   assign q_out   = q_ff[STAGES-1];

endmodule

`default_nettype wire

// File: hw/rtl/rta_out.sv
`timescale 1ns / 1ps
`default_nettype none

module rta_out #(
   parameter int OUT_FRAC_BITS = rta_pkg::OUT_FRAC_BITS_DEF
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  rta_pkg::ctl_type                    ctl_in,
   input  wire  [OUT_FRAC_BITS:0]              q_in,
   output logic                                up_ready,
   output logic                                rsp_valid,
   input  wire                                 rsp_ready,
   output logic signed [rta_pkg::Y_W-1:0]      rsp_tanh_value,
   output logic                                rsp_last_out
);

   localparam int Q_W   = OUT_FRAC_BITS + 1;
   localparam int RES_W = rta_pkg::max_int(Q_W, rta_pkg::Y_W) + 1;
   localparam logic [Q_W-1:0] ONE = Q_W'(1) << OUT_FRAC_BITS;

   // Clamp to one, apply sign, keep the low bits of the result
   logic [Q_W-1:0]          mag;
   logic [RES_W-1:0]        mag_x;
   logic [RES_W-1:0]        res;
   logic [rta_pkg::Y_W-1:0] y_in;

   always_comb begin
      mag   = (ctl_in.sat || (q_in > ONE)) ? ONE : q_in;
      mag_x = RES_W'(mag);
      res   = ctl_in.neg ? (~mag_x + 1'b1) : mag_x;
      y_in  = res[rta_pkg::Y_W-1:0];
   end

   // Output register plus one skid entry
   logic                    out_valid_ff, out_valid_in;
   logic [rta_pkg::Y_W-1:0] out_y_ff;
   logic                    out_last_ff;
   logic                    skid_valid_ff, skid_valid_in;
   logic [rta_pkg::Y_W-1:0] skid_y_ff;
   logic                    skid_last_ff;
   logic                    up_xfer;
   logic                    load_out_up;
   logic                    load_out_skid;
   logic                    load_skid;

   always_comb begin
      up_ready      = !skid_valid_ff;
      up_xfer       = ctl_in.valid && up_ready;
      load_out_skid = skid_valid_ff && rsp_ready;
      load_out_up   = up_xfer && (!out_valid_ff || rsp_ready);
      load_skid     = up_xfer && out_valid_ff && !rsp_ready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (load_out_skid) begin
         skid_valid_in = 1'b0;
      end else if (load_out_up) begin
         out_valid_in = 1'b1;
      end else if (load_skid) begin
         skid_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out_skid) begin
         out_y_ff    <= skid_y_ff;
         out_last_ff <= skid_last_ff;
      end else if (load_out_up) begin
         out_y_ff    <= y_in;
         out_last_ff <= ctl_in.last;
      end
      if (load_skid) begin
         skid_y_ff    <= y_in;
         skid_last_ff <= ctl_in.last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_tanh_value = out_y_ff;
   assign rsp_last_out   = out_last_ff;

endmodule

`default_nettype wire

// File: hw/rtl/rational_tanh_approximation.sv
// Rational tanh activation: tanh(x) ~ x*(27+x^2)/(27+9x^2), held at +/-1 beyond |x| = 3.
// Input channel req_*: req_x_sample is signed with IN_FRAC_BITS fraction bits,
// req_last_in marks the end of a tensor. A transfer happens when req_valid and
// req_ready are both high.
// Result channel rsp_*: rsp_tanh_value is signed with OUT_FRAC_BITS fraction bits
// (truncated toward zero), rsp_last_out is the matching last flag. One result
// per sample, in order.
// Datapath: four stages form |x|, x^2, x^3 and the numerator and denominator,
// then a restoring divider with one register stage per quotient bit, then the
// output register.
// Throughput: one sample per cycle unless stalled, set by the fully pipelined divider.
// Stall: when rsp_ready is low, the output register and one skid entry fill;
// after that req_ready drops and the whole pipeline holds. req_ready comes
// straight from a register.
// Reset: synchronous, active high; clears every valid bit, so the pipeline and
// the output are empty. Data registers are not reset.
`timescale 1ns / 1ps
`default_nettype none

module rational_tanh_approximation #(
   parameter int IN_FRAC_BITS  = rta_pkg::IN_FRAC_BITS_DEF,
   parameter int OUT_FRAC_BITS = rta_pkg::OUT_FRAC_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire  signed [rta_pkg::X_W-1:0]    req_x_sample,
   input  wire                               req_last_in,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic signed [rta_pkg::Y_W-1:0]    rsp_tanh_value,
   output logic                              rsp_last_out
);

   localparam int DEN_W = rta_pkg::den_width(IN_FRAC_BITS);
   localparam int REM_W = rta_pkg::rem_width(IN_FRAC_BITS);
   localparam int Q_W   = OUT_FRAC_BITS + 1;
   localparam logic [Q_W-1:0] ONE = Q_W'(1) << OUT_FRAC_BITS;

   logic             en;
   rta_pkg::ctl_type ctl_front;
   logic [REM_W-1:0] rem_front;
   logic [DEN_W-1:0] den_front;
   rta_pkg::ctl_type ctl_div;
   logic [Q_W-1:0]   q_div;

   // The pipeline moves whenever the skid entry is free
   assign req_ready = en;

   rta_front #(
      .IN_FRAC_BITS (IN_FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_valid),
      .in_x     (req_x_sample),
      .in_last  (req_last_in),
      .ctl_out  (ctl_front),
      .rem_out  (rem_front),
      .den_out  (den_front)
   );

   rta_div #(
      .IN_FRAC_BITS  (IN_FRAC_BITS),
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (ctl_front),
      .rem_in  (rem_front),
      .den_in  (den_front),
      .ctl_out (ctl_div),
      .q_out   (q_div)
   );

   rta_out #(
      .OUT_FRAC_BITS (OUT_FRAC_BITS)
   ) u_out (
      .clock          (clock),
      .reset          (reset),
      .ctl_in         (ctl_div),
      .q_in           (q_div),
      .up_ready       (en),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_tanh_value (rsp_tanh_value),
      .rsp_last_out   (rsp_last_out)
   );

   // In the rational range the quotient never exceeds one
   a_quot_bound: assert property (@(posedge clock) disable iff (reset)
      (ctl_div.valid && !ctl_div.sat) |-> (q_div <= ONE))
      else $error("divider quotient above one");

   // A held pipeline always has a result waiting at the output
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output");

   // Once a waiting result is taken, the skid entry drains and input reopens
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      (!req_ready && rsp_valid && rsp_ready) |=> req_ready)
      else $error("input did not reopen after output transfer");

endmodule

`default_nettype wire
